/* hw/rtl/bcis_pkg.sv */
package bcis_pkg;

    // Internal arithmetic width and the exact width of one ALU sum
    localparam int INT_W  = 64;
    localparam int EXT_W  = INT_W + 2;
    localparam int PROD_W = 2 * INT_W;
    localparam int DT_FRAC = 24;

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 24;
    localparam int COEF_W    = 31;
    localparam int WALL_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_G    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_R    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL = 3'd5;

    localparam logic [DT_W-1:0]          DT_RST   = 24'd16777;
    localparam logic [COEF_W-1:0]        G_RST    = 31'd642908;
    localparam logic [COEF_W-1:0]        K_RST    = 31'd13098680;
    localparam logic [COEF_W-1:0]        INVM_RST = 31'd24731;
    localparam logic [COEF_W-1:0]        R_RST    = 31'd9830;
    localparam logic signed [WALL_W-1:0] WALL_RST = 32'sd655360;

    // Product scaling
    typedef logic [1:0] shift_t;
    localparam shift_t SH_FRAC    = 2'd0;
    localparam shift_t SH_DT      = 2'd1;
    localparam shift_t SH_DT_HALF = 2'd2;

    // Operand sources and destinations
    typedef logic [4:0] src_t;
    localparam src_t SRC_ZERO = 5'd0;
    localparam src_t SRC_PX   = 5'd1;
    localparam src_t SRC_PY   = 5'd2;
    localparam src_t SRC_VX   = 5'd3;
    localparam src_t SRC_VY   = 5'd4;
    localparam src_t SRC_DT   = 5'd5;
    localparam src_t SRC_G    = 5'd6;
    localparam src_t SRC_K    = 5'd7;
    localparam src_t SRC_INVM = 5'd8;
    localparam src_t SRC_R    = 5'd9;
    localparam src_t SRC_WALL = 5'd10;
    localparam src_t SRC_T0   = 5'd11;
    localparam src_t SRC_T1   = 5'd12;
    localparam src_t SRC_T2   = 5'd13;
    localparam src_t SRC_T3   = 5'd14;
    localparam src_t SRC_T4   = 5'd15;
    localparam src_t SRC_T5   = 5'd16;
    localparam src_t SRC_T6   = 5'd17;

    typedef logic [2:0] op_t;
    localparam op_t OP_ADD = 3'd0;
    localparam op_t OP_SUB = 3'd1;
    localparam op_t OP_MUL = 3'd2;
    localparam op_t OP_JLE = 3'd3;

    typedef logic [4:0] pc_t;
    localparam pc_t PC_WALL  = 5'd8;
    localparam pc_t PC_ADV_X = 5'd13;
    localparam pc_t LAST_PC  = 5'd24;

    typedef struct packed {
        op_t    op;
        src_t   a;
        src_t   b;
        src_t   dst;
        shift_t sh;
        logic   wide;
        pc_t    target;
        logic   last;
    } uop_t;

    typedef struct packed {
        logic   start;
        shift_t sh;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } mul_stat_t;

    function automatic uop_t mk(op_t op, src_t a, src_t b, src_t dst, shift_t sh,
                                logic wide, pc_t target, logic last);
        uop_t u;
        u.op     = op;
        u.a      = a;
        u.b      = b;
        u.dst    = dst;
        u.sh     = sh;
        u.wide   = wide;
        u.target = target;
        u.last   = last;
        return u;
    endfunction

    // Step program. T0 = h, T1 = d, T2 = ay, T3 = ax, T4 = dv, T5 = dp.
    function automatic uop_t ucode(pc_t pc);
        uop_t u;
        case (pc)
            5'd0:  u = mk(OP_SUB, SRC_R,    SRC_PY,   SRC_T0,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd1:  u = mk(OP_ADD, SRC_PX,   SRC_R,    SRC_T1,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd2:  u = mk(OP_SUB, SRC_T1,   SRC_WALL, SRC_T1,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd3:  u = mk(OP_SUB, SRC_ZERO, SRC_G,    SRC_T2,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd4:  u = mk(OP_JLE, SRC_T0,   SRC_ZERO, SRC_ZERO, SH_FRAC,    1'b0, PC_WALL, 1'b0);
            5'd5:  u = mk(OP_MUL, SRC_K,    SRC_T0,   SRC_T2,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd6:  u = mk(OP_MUL, SRC_T2,   SRC_INVM, SRC_T2,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd7:  u = mk(OP_SUB, SRC_T2,   SRC_G,    SRC_T2,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd8:  u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_T3,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd9:  u = mk(OP_JLE, SRC_T1,   SRC_ZERO, SRC_ZERO, SH_FRAC,    1'b0, PC_ADV_X, 1'b0);
            5'd10: u = mk(OP_MUL, SRC_K,    SRC_T1,   SRC_T3,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd11: u = mk(OP_MUL, SRC_T3,   SRC_INVM, SRC_T3,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd12: u = mk(OP_SUB, SRC_ZERO, SRC_T3,   SRC_T3,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd13: u = mk(OP_MUL, SRC_T3,   SRC_DT,   SRC_T4,   SH_DT,      1'b0, '0, 1'b0);
            5'd14: u = mk(OP_MUL, SRC_VX,   SRC_DT,   SRC_T5,   SH_DT,      1'b0, '0, 1'b0);
            5'd15: u = mk(OP_MUL, SRC_T4,   SRC_DT,   SRC_T6,   SH_DT_HALF, 1'b0, '0, 1'b0);
            5'd16: u = mk(OP_ADD, SRC_T5,   SRC_T6,   SRC_T5,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd17: u = mk(OP_ADD, SRC_PX,   SRC_T5,   SRC_PX,   SH_FRAC,    1'b1, '0, 1'b0);
            5'd18: u = mk(OP_ADD, SRC_VX,   SRC_T4,   SRC_VX,   SH_FRAC,    1'b1, '0, 1'b0);
            5'd19: u = mk(OP_MUL, SRC_T2,   SRC_DT,   SRC_T4,   SH_DT,      1'b0, '0, 1'b0);
            5'd20: u = mk(OP_MUL, SRC_VY,   SRC_DT,   SRC_T5,   SH_DT,      1'b0, '0, 1'b0);
            5'd21: u = mk(OP_MUL, SRC_T4,   SRC_DT,   SRC_T6,   SH_DT_HALF, 1'b0, '0, 1'b0);
            5'd22: u = mk(OP_ADD, SRC_T5,   SRC_T6,   SRC_T5,   SH_FRAC,    1'b0, '0, 1'b0);
            5'd23: u = mk(OP_ADD, SRC_PY,   SRC_T5,   SRC_PY,   SH_FRAC,    1'b1, '0, 1'b0);
            5'd24: u = mk(OP_ADD, SRC_VY,   SRC_T4,   SRC_VY,   SH_FRAC,    1'b1, '0, 1'b1);
            default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, SH_FRAC, 1'b0, '0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

/* hw/rtl/bcis_mul.sv */
module bcis_mul #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bcis_pkg::mul_req_t                  req,
    input  logic signed [bcis_pkg::INT_W-1:0]   a,
    input  logic signed [bcis_pkg::INT_W-1:0]   b,
    output bcis_pkg::mul_stat_t                 stat,
    output logic signed [bcis_pkg::INT_W-1:0]   result
);

    localparam int INT_W  = bcis_pkg::INT_W;
    localparam int PROD_W = bcis_pkg::PROD_W;
    localparam int HALF_W = INT_W / 2;
    localparam logic [2:0] FINAL_CNT = 3'd4;
    localparam logic [PROD_W-1:0] ONE_P = PROD_W'(1);
    localparam logic [PROD_W-1:0] RND_FRAC = (ONE_P << FRACTION_BITS) - ONE_P;
    localparam logic [PROD_W-1:0] RND_DT   = (ONE_P << bcis_pkg::DT_FRAC) - ONE_P;
    localparam logic [PROD_W-1:0] RND_DT_H = (ONE_P << (bcis_pkg::DT_FRAC + 1)) - ONE_P;
    localparam logic [INT_W-1:0]  LIM_NEG  = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic [INT_W-1:0]  LIM_POS  = {1'b0, {(INT_W-1){1'b1}}};

    logic                 busy_reg;
    logic [2:0]           cnt_reg;
    logic [INT_W-1:0]     ua_reg;
    logic [INT_W-1:0]     ub_reg;
    logic                 neg_reg;
    bcis_pkg::shift_t     sh_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;

    logic [INT_W-1:0]     abs_a;
    logic [INT_W-1:0]     abs_b;
    logic                 neg;
    logic [PROD_W-1:0]    rnd;
    logic [HALF_W-1:0]    a_half;
    logic [HALF_W-1:0]    b_half;
    logic [INT_W-1:0]     part;
    logic [PROD_W-1:0]    part_sh;
    logic [PROD_W-1:0]    q;
    logic [INT_W-1:0]     lim;
    logic                 over;
    logic [INT_W-1:0]     mag;
    logic                 done;

    always_comb
    begin
        abs_a = a[INT_W-1] ? INT_W'(-a) : INT_W'(a);
        abs_b = b[INT_W-1] ? INT_W'(-b) : INT_W'(b);
        neg   = a[INT_W-1] ^ b[INT_W-1];
        case (req.sh)
            bcis_pkg::SH_FRAC:    rnd = RND_FRAC;
            bcis_pkg::SH_DT:      rnd = RND_DT;
            bcis_pkg::SH_DT_HALF: rnd = RND_DT_H;
            default:              rnd = '0;
        endcase
    end

    // Partial products in order a0*b0, a0*b1, a1*b0, a1*b1
    always_comb
    begin
        a_half = cnt_reg[1] ? ua_reg[INT_W-1:HALF_W] : ua_reg[HALF_W-1:0];
        b_half = cnt_reg[0] ? ub_reg[INT_W-1:HALF_W] : ub_reg[HALF_W-1:0];
        part   = a_half * b_half;
        case (cnt_reg[1:0])
            2'd0:    part_sh = PROD_W'(part);
            2'd1:    part_sh = PROD_W'(part) << HALF_W;
            2'd2:    part_sh = PROD_W'(part) << HALF_W;
            default: part_sh = PROD_W'(part) << INT_W;
        endcase
        acc_next = acc_reg + part_sh;
    end

    // Scale, saturate the magnitude, restore the sign
    always_comb
    begin
        case (sh_reg)
            bcis_pkg::SH_FRAC:    q = acc_reg >> FRACTION_BITS;
            bcis_pkg::SH_DT:      q = acc_reg >> bcis_pkg::DT_FRAC;
            bcis_pkg::SH_DT_HALF: q = acc_reg >> (bcis_pkg::DT_FRAC + 1);
            default:              q = acc_reg;
        endcase
        lim    = neg_reg ? LIM_NEG : LIM_POS;
        over   = (q[PROD_W-1:INT_W] != '0) || (q[INT_W-1:0] > lim);
        mag    = over ? lim : q[INT_W-1:0];
        result = neg_reg ? -mag : mag;
    end

    assign done      = busy_reg && (cnt_reg == FINAL_CNT);
    assign stat.busy = busy_reg;
    assign stat.done = done;
    assign stat.sat  = over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ua_reg  <= abs_a;
            ub_reg  <= abs_b;
            neg_reg <= neg;
            sh_reg  <= req.sh;
            // seed with the floor correction for negative products
            acc_reg <= neg ? rnd : '0;
        end
        else if (busy_reg && !done)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* hw/rtl/ball_contact_integration_step_top.sv */
// Ball with spring contact against a floor at y = 0 and a wall at x = wall position,
// state held in signed fixed point (VALUE_WIDTH bits, FRACTION_BITS fraction bits).
// A load request (req_type 0) stores the four fields and returns them, by way of the
// hold state, with saturated low. A step request (req_type 1) runs a 25-step
// microprogram on one adder/clipper and one shared multiplier: each product passes
// through the 32x32 multiplier as a load, four partial products and a scaling; a
// step runs the force products only for a contact that is present. The finished
// state then moves to the output register. One request is in work at a time; a new
// request is taken as soon as the previous result sits in the output register, even
// if it is not yet taken. saturated reports any clip at the 64-bit intermediate
// limits or the state range.
module ball_contact_integration_step_top #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_en,
    input  logic [bcis_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bcis_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  req_type,
    input  logic signed [VALUE_WIDTH-1:0]         load_pos_x,
    input  logic signed [VALUE_WIDTH-1:0]         load_pos_y,
    input  logic signed [VALUE_WIDTH-1:0]         load_vel_x,
    input  logic signed [VALUE_WIDTH-1:0]         load_vel_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [VALUE_WIDTH-1:0]         pos_x,
    output logic signed [VALUE_WIDTH-1:0]         pos_y,
    output logic signed [VALUE_WIDTH-1:0]         vel_x,
    output logic signed [VALUE_WIDTH-1:0]         vel_y,
    output logic                                  saturated
);

    localparam int INT_W = bcis_pkg::INT_W;
    localparam int EXT_W = bcis_pkg::EXT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic signed [EXT_W-1:0] MAX_I = (EXT_W'(1) << (INT_W - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] MIN_I = -MAX_I - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] MAX_V = (EXT_W'(1) << (VALUE_WIDTH - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] MIN_V = -MAX_V - EXT_W'(1);

    // configuration
    logic [bcis_pkg::DT_W-1:0]          dt_reg;
    logic [bcis_pkg::COEF_W-1:0]        g_reg;
    logic [bcis_pkg::COEF_W-1:0]        k_reg;
    logic [bcis_pkg::COEF_W-1:0]        invm_reg;
    logic [bcis_pkg::COEF_W-1:0]        r_reg;
    logic signed [bcis_pkg::WALL_W-1:0] wall_reg;

    // control
    logic [1:0]          state_reg;
    bcis_pkg::pc_t       pc_reg;
    logic                sat_reg;
    logic                out_valid_reg;

    // ball state and scratch
    logic signed [VALUE_WIDTH-1:0] px_reg;
    logic signed [VALUE_WIDTH-1:0] py_reg;
    logic signed [VALUE_WIDTH-1:0] vx_reg;
    logic signed [VALUE_WIDTH-1:0] vy_reg;
    logic signed [INT_W-1:0]       t0_reg;
    logic signed [INT_W-1:0]       t1_reg;
    logic signed [INT_W-1:0]       t2_reg;
    logic signed [INT_W-1:0]       t3_reg;
    logic signed [INT_W-1:0]       t4_reg;
    logic signed [INT_W-1:0]       t5_reg;
    logic signed [INT_W-1:0]       t6_reg;

    // output register
    logic signed [VALUE_WIDTH-1:0] pos_x_reg;
    logic signed [VALUE_WIDTH-1:0] pos_y_reg;
    logic signed [VALUE_WIDTH-1:0] vel_x_reg;
    logic signed [VALUE_WIDTH-1:0] vel_y_reg;
    logic                          saturated_reg;

    bcis_pkg::uop_t        uop;
    logic signed [INT_W-1:0] opa;
    logic signed [INT_W-1:0] opb;
    logic signed [EXT_W-1:0] sum;
    logic signed [EXT_W-1:0] hi_lim;
    logic signed [EXT_W-1:0] lo_lim;
    logic                    clip_hi;
    logic                    clip_lo;
    logic signed [EXT_W-1:0] alu_res;
    logic                    alu_sat;
    logic signed [INT_W-1:0] mul_result;
    logic signed [INT_W-1:0] wr_data;
    logic                    wr_en;
    logic                    is_alu;
    logic                    le0;
    logic                    step_adv;
    bcis_pkg::pc_t           pc_next;
    logic                    take;
    logic                    load_take;
    logic                    out_free;
    bcis_pkg::mul_req_t      mul_req;
    bcis_pkg::mul_stat_t     mul_st;

    function automatic logic signed [INT_W-1:0] pick(bcis_pkg::src_t s);
        logic signed [INT_W-1:0] v;
        case (s)
            bcis_pkg::SRC_PX:   v = INT_W'(px_reg);
            bcis_pkg::SRC_PY:   v = INT_W'(py_reg);
            bcis_pkg::SRC_VX:   v = INT_W'(vx_reg);
            bcis_pkg::SRC_VY:   v = INT_W'(vy_reg);
            bcis_pkg::SRC_DT:   v = INT_W'(dt_reg);
            bcis_pkg::SRC_G:    v = INT_W'(g_reg);
            bcis_pkg::SRC_K:    v = INT_W'(k_reg);
            bcis_pkg::SRC_INVM: v = INT_W'(invm_reg);
            bcis_pkg::SRC_R:    v = INT_W'(r_reg);
            bcis_pkg::SRC_WALL: v = INT_W'(wall_reg);
            bcis_pkg::SRC_T0:   v = t0_reg;
            bcis_pkg::SRC_T1:   v = t1_reg;
            bcis_pkg::SRC_T2:   v = t2_reg;
            bcis_pkg::SRC_T3:   v = t3_reg;
            bcis_pkg::SRC_T4:   v = t4_reg;
            bcis_pkg::SRC_T5:   v = t5_reg;
            bcis_pkg::SRC_T6:   v = t6_reg;
            default:            v = '0;
        endcase
        return v;
    endfunction

    assign take      = in_valid && in_ready;
    assign load_take = take && !req_type;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        uop = bcis_pkg::ucode(pc_reg);
        opa = pick(uop.a);
        opb = pick(uop.b);
    end

    // Exact sum, then one clip to either the 64-bit or the state range
    always_comb
    begin
        if (uop.op == bcis_pkg::OP_SUB)
        begin
            sum = EXT_W'(opa) - EXT_W'(opb);
        end
        else
        begin
            sum = EXT_W'(opa) + EXT_W'(opb);
        end
        hi_lim  = uop.wide ? MAX_V : MAX_I;
        lo_lim  = uop.wide ? MIN_V : MIN_I;
        clip_hi = (sum > hi_lim);
        clip_lo = (sum < lo_lim);
        alu_res = clip_hi ? hi_lim : (clip_lo ? lo_lim : sum);
        alu_sat = clip_hi || clip_lo;
    end

    always_comb
    begin
        is_alu   = (uop.op == bcis_pkg::OP_ADD) || (uop.op == bcis_pkg::OP_SUB);
        le0      = opa[INT_W-1] || (opa == '0);
        step_adv = (state_reg == ST_RUN) &&
                   (is_alu || (uop.op == bcis_pkg::OP_JLE) ||
                    ((uop.op == bcis_pkg::OP_MUL) && mul_st.done));
        pc_next  = ((uop.op == bcis_pkg::OP_JLE) && le0) ? uop.target : pc_reg + 5'd1;
        wr_en    = (state_reg == ST_RUN) &&
                   (is_alu || ((uop.op == bcis_pkg::OP_MUL) && mul_st.done));
        wr_data  = (uop.op == bcis_pkg::OP_MUL) ? mul_result : alu_res[INT_W-1:0];
    end

    assign mul_req.start = (state_reg == ST_RUN) && (uop.op == bcis_pkg::OP_MUL) &&
                           !mul_st.busy;
    assign mul_req.sh    = uop.sh;

    bcis_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .a      (opa),
        .b      (opb),
        .stat   (mul_st),
        .result (mul_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg   <= bcis_pkg::DT_RST;
            g_reg    <= bcis_pkg::G_RST;
            k_reg    <= bcis_pkg::K_RST;
            invm_reg <= bcis_pkg::INVM_RST;
            r_reg    <= bcis_pkg::R_RST;
            wall_reg <= bcis_pkg::WALL_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                bcis_pkg::CFG_DT:   dt_reg   <= cfg_data[bcis_pkg::DT_W-1:0];
                bcis_pkg::CFG_G:    g_reg    <= cfg_data[bcis_pkg::COEF_W-1:0];
                bcis_pkg::CFG_K:    k_reg    <= cfg_data[bcis_pkg::COEF_W-1:0];
                bcis_pkg::CFG_INVM: invm_reg <= cfg_data[bcis_pkg::COEF_W-1:0];
                bcis_pkg::CFG_R:    r_reg    <= cfg_data[bcis_pkg::COEF_W-1:0];
                bcis_pkg::CFG_WALL: wall_reg <= cfg_data[bcis_pkg::WALL_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        sat_reg   <= 1'b0;
                        pc_reg    <= '0;
                        state_reg <= req_type ? ST_RUN : ST_HOLD;
                    end
                end
                ST_RUN:
                begin
                    if (wr_en)
                    begin
                        sat_reg <= sat_reg || (is_alu ? alu_sat : mul_st.sat);
                    end
                    if (step_adv)
                    begin
                        if (uop.last)
                        begin
                            state_reg <= ST_HOLD;
                        end
                        else
                        begin
                            pc_reg <= pc_next;
                        end
                    end
                end
                ST_HOLD:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
        end
        else if (load_take)
        begin
            px_reg <= load_pos_x;
            py_reg <= load_pos_y;
            vx_reg <= load_vel_x;
            vy_reg <= load_vel_y;
        end
        else if (wr_en)
        begin
            case (uop.dst)
                bcis_pkg::SRC_PX: px_reg <= wr_data[VALUE_WIDTH-1:0];
                bcis_pkg::SRC_PY: py_reg <= wr_data[VALUE_WIDTH-1:0];
                bcis_pkg::SRC_VX: vx_reg <= wr_data[VALUE_WIDTH-1:0];
                bcis_pkg::SRC_VY: vy_reg <= wr_data[VALUE_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (uop.dst)
                bcis_pkg::SRC_T0: t0_reg <= wr_data;
                bcis_pkg::SRC_T1: t1_reg <= wr_data;
                bcis_pkg::SRC_T2: t2_reg <= wr_data;
                bcis_pkg::SRC_T3: t3_reg <= wr_data;
                bcis_pkg::SRC_T4: t4_reg <= wr_data;
                bcis_pkg::SRC_T5: t5_reg <= wr_data;
                bcis_pkg::SRC_T6: t6_reg <= wr_data;
                default:          ;
            endcase
        end
        if ((state_reg == ST_HOLD) && out_free)
        begin
            pos_x_reg     <= px_reg;
            pos_y_reg     <= py_reg;
            vel_x_reg     <= vx_reg;
            vel_y_reg     <= vy_reg;
            saturated_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign saturated = saturated_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        mul_st.done |-> (state_reg == ST_RUN))
        else $error("multiplier finished outside a step program");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (pc_reg <= bcis_pkg::LAST_PC))
        else $error("program counter ran past the step program");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HOLD) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished result not moved to the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_take |=> ((state_reg == ST_HOLD) && !sat_reg))
        else $error("load request left a saturation flag or skipped hand-off");

endmodule

/* tb/sv/ball_contact_integration_step_top_test.sv */
module ball_contact_integration_step_top_test;

    localparam int VALUE_W  = 32;
    localparam int FRACTION = 16;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Indexes with no register behind them
    localparam logic [bcis_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [bcis_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] P_MIN = 32'h8000_0000;

    localparam int DIRECTED_ROWS   = 20;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 143;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 100;

    typedef logic signed [63:0]  s64_t;
    typedef logic signed [127:0] s128_t;

    localparam s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic        req_type;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
    } request_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic        saturated;
    } ball_state_t;

    typedef struct packed {
        request_t    rq;
        logic        known;
        ball_state_t state;
    } directed_row_t;

    localparam logic [129:0] FROM_PREDICTOR = '0;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_en;
    logic [bcis_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [bcis_pkg::CFG_W-1:0]       cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic                             req_type;
    logic signed [31:0]               load_pos_x;
    logic signed [31:0]               load_pos_y;
    logic signed [31:0]               load_vel_x;
    logic signed [31:0]               load_vel_y;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [31:0]               pos_x;
    logic signed [31:0]               pos_y;
    logic signed [31:0]               vel_x;
    logic signed [31:0]               vel_y;
    logic                             saturated;

    // Predicted ball state and register copies
    logic signed [31:0]          ball_px, ball_py, ball_vx, ball_vy;
    logic [bcis_pkg::DT_W-1:0]   step_dt;
    logic [bcis_pkg::COEF_W-1:0] gravity, stiffness, inv_mass, radius;
    logic signed [31:0]          wall_x;
    bit                          step_clipped;

    ball_state_t   pending_states[$];
    directed_row_t directed_rows[DIRECTED_ROWS];
    int            errors_seen;
    int            results_taken;
    int            send_calm;
    int            take_calm;

    ball_contact_integration_step_top #(
        .VALUE_WIDTH   (VALUE_W),
        .FRACTION_BITS (FRACTION)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .load_pos_x (load_pos_x),
        .load_pos_y (load_pos_y),
        .load_vel_x (load_vel_x),
        .load_vel_y (load_vel_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .saturated  (saturated)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic s64_t limit64(s128_t v);
        s64_t res;
        if (v > s128_t'(S64_MAX))
        begin
            step_clipped = 1'b1;
            res = S64_MAX;
        end
        else if (v < s128_t'(S64_MIN))
        begin
            step_clipped = 1'b1;
            res = S64_MIN;
        end
        else
            res = $signed(v[63:0]);
        return res;
    endfunction

    function automatic s64_t add_sat(s64_t a, s64_t b);
        return limit64(s128_t'(a) + s128_t'(b));
    endfunction

    function automatic s64_t sub_sat(s64_t a, s64_t b);
        return limit64(s128_t'(a) - s128_t'(b));
    endfunction

    // Product scaled down by 2^sh, rounded toward minus infinity
    function automatic s64_t mul_floor(s64_t a, s64_t b, int unsigned sh);
        s128_t p;
        p = s128_t'(a) * s128_t'(b);
        return limit64(p >>> sh);
    endfunction

    function automatic logic signed [31:0] clip_value(s64_t v);
        logic signed [31:0] res;
        if (v > s64_t'(32'sh7FFF_FFFF))
        begin
            step_clipped = 1'b1;
            res = 32'sh7FFF_FFFF;
        end
        else if (v < s64_t'(32'sh8000_0000))
        begin
            step_clipped = 1'b1;
            res = 32'sh8000_0000;
        end
        else
            res = v[31:0];
        return res;
    endfunction

    task automatic advance_axis(inout logic signed [31:0] pos, inout logic signed [31:0] vel,
                                input s64_t acc);
        s64_t dt, dv, dp;
        dt = $signed({40'b0, step_dt});
        dv = mul_floor(acc, dt, bcis_pkg::DT_FRAC);
        // position uses the velocity from before this step
        dp = add_sat(mul_floor(s64_t'(vel), dt, bcis_pkg::DT_FRAC),
                     mul_floor(dv, dt, bcis_pkg::DT_FRAC + 1));
        pos = clip_value(add_sat(s64_t'(pos), dp));
        vel = clip_value(add_sat(s64_t'(vel), dv));
    endtask

    task automatic predict_request(input request_t rq, output ball_state_t res);
        s64_t k, invm, r, g, wall, h, d, ay, ax;
        step_clipped = 1'b0;
        if (rq.req_type == REQ_LOAD)
        begin
            ball_px = rq.px;
            ball_py = rq.py;
            ball_vx = rq.vx;
            ball_vy = rq.vy;
        end
        else
        begin
            k    = $signed({33'b0, stiffness});
            invm = $signed({33'b0, inv_mass});
            r    = $signed({33'b0, radius});
            g    = $signed({33'b0, gravity});
            wall = s64_t'(wall_x);
            h = sub_sat(r, s64_t'(ball_py));
            d = sub_sat(add_sat(s64_t'(ball_px), r), wall);
            ay = '0;
            ax = '0;
            if (h > 0)
                ay = mul_floor(mul_floor(k, h, FRACTION), invm, FRACTION);
            ay = sub_sat(ay, g);
            if (d > 0)
                ax = -mul_floor(mul_floor(k, d, FRACTION), invm, FRACTION);
            advance_axis(ball_px, ball_vx, ax);
            advance_axis(ball_py, ball_vy, ay);
        end
        res = {ball_px, ball_py, ball_vx, ball_vy, step_clipped};
    endtask

    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 12);
    endtask

    function automatic logic [31:0] pick_value(logic [31:0] center, int span);
        logic [31:0] v;
        case ($urandom_range(0, 11))
            0:       v = P_MIN;
            1:       v = P_MAX;
            2, 3:    v = $urandom;
            default: v = center + $urandom_range(0, 2 * span) - span;
        endcase
        return v;
    endfunction

    // Mostly steps, with a load now and then to start a fresh trajectory near contact
    function automatic request_t random_request();
        request_t rq;
        rq.req_type = ($urandom_range(0, 9) < 2) ? REQ_LOAD : REQ_STEP;
        rq.px = pick_value(wall_x - {1'b0, radius}, 2 << FRACTION);
        rq.py = pick_value({1'b0, radius}, 1 << FRACTION);
        rq.vx = pick_value(32'd0, 4 << FRACTION);
        rq.vy = pick_value(32'd0, 4 << FRACTION);
        return rq;
    endfunction

    task automatic write_register(input logic [bcis_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bcis_pkg::CFG_W-1:0] data);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            bcis_pkg::CFG_DT:   step_dt   = data[bcis_pkg::DT_W-1:0];
            bcis_pkg::CFG_G:    gravity   = data[bcis_pkg::COEF_W-1:0];
            bcis_pkg::CFG_K:    stiffness = data[bcis_pkg::COEF_W-1:0];
            bcis_pkg::CFG_INVM: inv_mass  = data[bcis_pkg::COEF_W-1:0];
            bcis_pkg::CFG_R:    radius    = data[bcis_pkg::COEF_W-1:0];
            bcis_pkg::CFG_WALL: wall_x    = data[bcis_pkg::WALL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_phase(input int phase);
        case (phase)
            1:
            begin
                write_register(bcis_pkg::CFG_DT, 32'd33554);
                write_register(bcis_pkg::CFG_G, 32'd642908);
                write_register(bcis_pkg::CFG_K, 32'd26197360);
                write_register(bcis_pkg::CFG_INVM, 32'd65536);
                write_register(bcis_pkg::CFG_R, 32'd16384);
                write_register(bcis_pkg::CFG_WALL, 32'd196608);
            end
            2:
            begin
                // all ones, the wall at P_MAX: upper bits beyond each register width get dropped
                write_register(bcis_pkg::CFG_DT, 32'hFFFF_FFFF);
                write_register(bcis_pkg::CFG_G, 32'hFFFF_FFFF);
                write_register(bcis_pkg::CFG_K, 32'hFFFF_FFFF);
                write_register(bcis_pkg::CFG_INVM, 32'hFFFF_FFFF);
                write_register(bcis_pkg::CFG_R, 32'hFFFF_FFFF);
                write_register(bcis_pkg::CFG_WALL, P_MAX);
            end
            3:
            begin
                write_register(bcis_pkg::CFG_DT, 32'd1);
                write_register(bcis_pkg::CFG_G, 32'd0);
                write_register(bcis_pkg::CFG_K, 32'd0);
                write_register(bcis_pkg::CFG_INVM, 32'd1);
                write_register(bcis_pkg::CFG_R, 32'd0);
                write_register(bcis_pkg::CFG_WALL, P_MIN);
            end
            4:
            begin
                // zero time step and zero inverse mass, then writes to unused indexes
                write_register(bcis_pkg::CFG_DT, 32'd0);
                write_register(bcis_pkg::CFG_G, 32'd642908);
                write_register(bcis_pkg::CFG_K, 32'd13098680);
                write_register(bcis_pkg::CFG_INVM, 32'd0);
                write_register(bcis_pkg::CFG_R, 32'd9830);
                write_register(bcis_pkg::CFG_WALL, 32'd655360);
                write_register(CFG_SPARE_A, 32'hFFFF_FFFF);
                write_register(CFG_SPARE_B, 32'h1234_5678);
            end
            default:
            begin
                write_register(bcis_pkg::CFG_DT,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 65535));
                write_register(bcis_pkg::CFG_G,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20 << FRACTION));
                write_register(bcis_pkg::CFG_K,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000 << FRACTION));
                write_register(bcis_pkg::CFG_INVM,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4 << FRACTION));
                write_register(bcis_pkg::CFG_R,
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << FRACTION));
                write_register(bcis_pkg::CFG_WALL,
                    ($urandom_range(0, 3) == 0) ? $urandom
                                                : $urandom_range(0, 32 << FRACTION) - (16 << FRACTION));
            end
        endcase
        cfg_en <= 1'b0;
    endtask

    task automatic send_request(input request_t rq, input logic known, input ball_state_t known_state);
        int gap;
        ball_state_t predicted;
        draw_gap(send_calm, gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq.req_type;
        load_pos_x <= rq.px;
        load_pos_y <= rq.py;
        load_vel_x <= rq.vx;
        load_vel_y <= rq.vy;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predict_request(rq, predicted);
        pending_states.push_back(known ? known_state : predicted);
    endtask

    // Drop valid and wait until every request has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_states.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_state(input ball_state_t want);
        if (pos_x !== want.pos_x)
        begin
            $error("pos_x: expected %0d, got %0d", $signed(want.pos_x), pos_x);
            errors_seen++;
        end
        if (pos_y !== want.pos_y)
        begin
            $error("pos_y: expected %0d, got %0d", $signed(want.pos_y), pos_y);
            errors_seen++;
        end
        if (vel_x !== want.vel_x)
        begin
            $error("vel_x: expected %0d, got %0d", $signed(want.vel_x), vel_x);
            errors_seen++;
        end
        if (vel_y !== want.vel_y)
        begin
            $error("vel_y: expected %0d, got %0d", $signed(want.vel_y), vel_y);
            errors_seen++;
        end
        if (saturated !== want.saturated)
        begin
            $error("saturated: expected %0d, got %0d", want.saturated, saturated);
            errors_seen++;
        end
    endtask

    // Result side
    initial
    begin
        int gap;
        ball_state_t want;
        out_ready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            draw_gap(take_calm, gap);
            // hold off long enough for the block to back up into its input
            if (results_taken == 300 || results_taken == 900)
                gap = LONG_HOLD;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            results_taken++;
            if (pending_states.size() == 0)
            begin
                $error("result with no request pending");
                errors_seen++;
            end
            else
            begin
                want = pending_states.pop_front();
                compare_state(want);
            end
        end
    end

    initial
    begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        request_t rq;
        cfg_en     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = REQ_LOAD;
        load_pos_x = '0;
        load_pos_y = '0;
        load_vel_x = '0;
        load_vel_y = '0;
        rst_n      = 1'b0;

        step_dt   = bcis_pkg::DT_RST;
        gravity   = bcis_pkg::G_RST;
        stiffness = bcis_pkg::K_RST;
        inv_mass  = bcis_pkg::INVM_RST;
        radius    = bcis_pkg::R_RST;
        wall_x    = bcis_pkg::WALL_RST;
        ball_px   = '0;
        ball_py   = '0;
        ball_vx   = '0;
        ball_vy   = '0;

        directed_rows[0]  = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        directed_rows[1]  = {REQ_LOAD, 128'b0, 1'b1, 128'b0, 1'b0};
        directed_rows[2]  = {REQ_LOAD, P_MAX, P_MAX, P_MAX, P_MAX,
                             1'b1, P_MAX, P_MAX, P_MAX, P_MAX, 1'b0};
        directed_rows[3]  = {REQ_STEP, {4{32'hA5A5_A5A5}}, FROM_PREDICTOR};
        directed_rows[4]  = {REQ_LOAD, P_MIN, P_MIN, P_MIN, P_MIN,
                             1'b1, P_MIN, P_MIN, P_MIN, P_MIN, 1'b0};
        directed_rows[5]  = {REQ_STEP, {4{32'h5A5A_5A5A}}, FROM_PREDICTOR};
        directed_rows[6]  = {REQ_STEP, {4{32'hFFFF_FFFF}}, FROM_PREDICTOR};
        directed_rows[7]  = {REQ_LOAD, P_MAX, P_MIN, P_MIN, P_MAX,
                             1'b1, P_MAX, P_MIN, P_MIN, P_MAX, 1'b0};
        directed_rows[8]  = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        // resting exactly one radius above the floor
        directed_rows[9]  = {REQ_LOAD, 32'd0, 32'd9830, 32'd0, 32'd0,
                             1'b1, 32'd0, 32'd9830, 32'd0, 32'd0, 1'b0};
        directed_rows[10] = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        directed_rows[11] = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        // touching the wall, moving toward it
        directed_rows[12] = {REQ_LOAD, 32'd645530, 32'd65536, 32'd327680, 32'd0,
                             1'b1, 32'd645530, 32'd65536, 32'd327680, 32'd0, 1'b0};
        directed_rows[13] = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        directed_rows[14] = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        directed_rows[15] = {REQ_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                             1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                             1'b0};
        directed_rows[16] = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        // one LSB into both floor and wall
        directed_rows[17] = {REQ_LOAD, 32'd645531, 32'd9829, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, 32'd645531, 32'd9829, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0};
        directed_rows[18] = {REQ_STEP, 128'b0, FROM_PREDICTOR};
        directed_rows[19] = {REQ_STEP, 128'b0, FROM_PREDICTOR};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].rq, directed_rows[i].known, directed_rows[i].state);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                settle();
                program_phase(phase);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                rq = random_request();
                send_request(rq, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors_seen == 0 && pending_states.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* ball_contact_integration_step_top.f */
hw/rtl/bcis_pkg.sv
hw/rtl/bcis_mul.sv
hw/rtl/ball_contact_integration_step_top.sv
tb/sv/ball_contact_integration_step_top_test.sv
